// ===== src/bcdec_pkg.sv =====
// shared types, codes and arithmetic helpers for the bc1/bc2/bc3 block decoder
package bcdec_pkg;

  // texture format codes; the last code decodes like bc3
  localparam logic [1:0] FMT_BC1  = 2'd0;
  localparam logic [1:0] FMT_BC2  = 2'd1;
  localparam logic [1:0] FMT_BC3  = 2'd2;
  localparam logic [1:0] FMT_RSVD = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int unsigned DimW = 13;
  localparam logic [DimW-1:0] MAX_DIM = 13'd4096;

  localparam int unsigned NumLanes = 4;

  // decoded palettes of one block
  typedef struct packed {
    logic [3:0][23:0] rgb;    // colour entries, b[23:16] g[15:8] r[7:0]
    logic             a3;     // alpha of colour entry 3 is 255 when set
    logic [7:0][7:0]  alpha;  // bc3 alpha entries
  } pal_t;

  // per-lane selection codes for one texel
  typedef struct packed {
    logic [1:0] cidx;
    logic [3:0] nib;
    logic [2:0] aidx;
  } lane_sel_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // floor(x/3) for x <= 765 by reciprocal multiply
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    return p[18:11];
  endfunction

  // floor(x/7) for x <= 1785
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // floor(x/5) for x <= 1275
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

endpackage

// ===== src/bcdec_palette.sv =====
// colour and alpha palette builder for one compressed block
module bcdec_palette import bcdec_pkg::*; (
  input  logic [1:0]  fmt_i,
  input  logic [31:0] color_ep_i,
  input  logic [15:0] alpha_ep_i,
  output pal_t        pal_o
);

  logic [15:0] c0, c1;
  logic [2:0][7:0] e0, e1;
  logic        punch;
  logic [7:0]  a0, a1;
  logic [3:0][23:0] rgb_pal;
  logic             keep_a3;
  logic [7:0][7:0]  alpha_pal;

  assign c0 = color_ep_i[15:0];
  assign c1 = color_ep_i[31:16];
  assign a0 = alpha_ep_i[7:0];
  assign a1 = alpha_ep_i[15:8];

  // only bc1 switches to punch-through mode
  assign punch = (fmt_i == FMT_BC1) && (c0 <= c1);

  always_comb begin
    e0[0] = expand5(c0[15:11]);
    e0[1] = expand6(c0[10:5]);
    e0[2] = expand5(c0[4:0]);
    e1[0] = expand5(c1[15:11]);
    e1[1] = expand6(c1[10:5]);
    e1[2] = expand5(c1[4:0]);
  end

  always_comb begin
    logic [9:0] s2, s3;
    logic [8:0] sh;
    rgb_pal = '0;
    rgb_pal[0] = {e0[2], e0[1], e0[0]};
    rgb_pal[1] = {e1[2], e1[1], e1[0]};
    keep_a3 = !punch;
    for (int c = 0; c < 3; c++) begin
      s2 = {1'b0, e0[c], 1'b0} + {2'b00, e1[c]};
      s3 = {2'b00, e0[c]} + {1'b0, e1[c], 1'b0};
      sh = {1'b0, e0[c]} + {1'b0, e1[c]};
      if (punch) begin
        rgb_pal[2][8*c +: 8] = sh[8:1];
        rgb_pal[3][8*c +: 8] = 8'd0;
      end else begin
        rgb_pal[2][8*c +: 8] = div3(s2);
        rgb_pal[3][8*c +: 8] = div3(s3);
      end
    end
  end

  always_comb begin
    logic [10:0] acc7, acc5;
    alpha_pal[0] = a0;
    alpha_pal[1] = a1;
    for (int i = 1; i < 7; i++) begin
      acc7 = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
      acc5 = 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
      if (a0 > a1) begin
        alpha_pal[i + 1] = div7(acc7);
      end else if (i < 5) begin
        alpha_pal[i + 1] = div5(acc5);
      end else if (i == 5) begin
        alpha_pal[i + 1] = 8'd0;
      end else begin
        alpha_pal[i + 1] = 8'd255;
      end
    end
  end

  assign pal_o = '{rgb: rgb_pal, a3: keep_a3, alpha: alpha_pal};

endmodule

// ===== src/bcdec_lane.sv =====
// one texel column lane: palette lookup, alpha merge and horizontal clip
module bcdec_lane import bcdec_pkg::*; (
  input  logic [1:0]      fmt_i,
  input  pal_t            pal_i,
  input  lane_sel_t       sel_i,
  input  logic [1:0]      lane_idx_i,
  input  logic [9:0]      block_col_i,
  input  logic [DimW-1:0] width_i,
  output logic [31:0]     texel_o,
  output logic            col_ok_o
);

  logic [23:0] rgb;
  logic [7:0]  alpha;
  logic [11:0] x;

  always_comb begin
    case (sel_i.cidx)
      2'd0:    rgb = pal_i.rgb[0];
      2'd1:    rgb = pal_i.rgb[1];
      2'd2:    rgb = pal_i.rgb[2];
      default: rgb = pal_i.rgb[3];
    endcase
  end

  always_comb begin
    case (fmt_i)
      FMT_BC1: alpha = (sel_i.cidx == 2'd3 && !pal_i.a3) ? 8'd0 : 8'd255;
      FMT_BC2: alpha = {sel_i.nib, sel_i.nib};
      default: alpha = pal_i.alpha[sel_i.aidx];
    endcase
  end

  assign texel_o  = {alpha, rgb};
  assign x        = {block_col_i, lane_idx_i};
  assign col_ok_o = ({1'b0, x} < width_i);

endmodule

// ===== src/bc1_bc2_bc3_block_decoder.sv =====
// top level of the bc1/bc2/bc3 block decoder: config, block register, lanes, row output
//
// Decodes one 4x4 compressed block (bc1, bc2 or bc3, chosen by texture_format) into four
// row transactions, top row first, each carrying four RGBA8 texels and a mask of the
// texels that lie inside the image (image_width/height, clamped to 4096). The palettes
// are built from the input transaction and registered together with the index bits; a
// row sequencer then drives four lanes, one per texel column, and registers one row per
// cycle into the output stage unless a stalled row is held there. The next block is
// accepted as its last row is registered into the output stage, so blocks stream with
// no gap. Each block passes the block register, then the output register. Configuration
// must only change while the block is idle.
module bc1_bc2_bc3_block_decoder import bcdec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  input  logic [9:0]  block_col_i,
  input  logic [9:0]  block_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  row_in_block_o,
  output logic [31:0] texel_a_o,
  output logic [31:0] texel_b_o,
  output logic [31:0] texel_c_o,
  output logic [31:0] texel_d_o,
  output logic [3:0]  texel_valid_o,
  output logic        last_row_o
);

  logic [1:0]      fmt_q;
  logic [DimW-1:0] width_q, height_q, dim_clamped;

  assign dim_clamped = (cfg_data_i > MAX_DIM) ? MAX_DIM : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_BC1;
      width_q  <= 13'd4;
      height_q <= 13'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FORMAT: fmt_q    <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= dim_clamped;
        REG_HEIGHT: height_q <= dim_clamped;
        default: ;
      endcase
    end
  end

  // palette build on the incoming block
  logic [63:0] cblk;
  pal_t        pal_d;

  assign cblk = (fmt_q == FMT_BC1) ? block_low_i : block_high_i;

  bcdec_palette u_palette (
    .fmt_i      (fmt_q),
    .color_ep_i (cblk[31:0]),
    .alpha_ep_i (block_low_i[15:0]),
    .pal_o      (pal_d)
  );

  // block register and row sequencer
  logic        blk_valid_q;
  logic [1:0]  row_cnt_q;
  pal_t        pal_q;
  logic [31:0] idx_q;
  logic [63:0] alo_q;
  logic [9:0]  bcol_q, brow_q;
  logic        in_acc, adv, blk_done;

  assign adv        = blk_valid_q && (!out_valid_o || !out_stall_i);
  assign blk_done   = adv && (row_cnt_q == 2'd3);
  assign in_stall_o = blk_valid_q && !blk_done;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
      row_cnt_q   <= 2'd0;
    end else begin
      if (in_acc) begin
        blk_valid_q <= 1'b1;
        row_cnt_q   <= 2'd0;
      end else begin
        if (blk_done) begin
          blk_valid_q <= 1'b0;
        end
        if (adv) begin
          row_cnt_q <= row_cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pal_q  <= pal_d;
      idx_q  <= cblk[63:32];
      alo_q  <= block_low_i;
      bcol_q <= block_col_i;
      brow_q <= block_row_i;
    end
  end

  // row slices of the index words
  logic [7:0]  cidx_row;
  logic [15:0] nib_row;
  logic [11:0] aidx_row;

  always_comb begin
    case (row_cnt_q)
      2'd0: begin
        cidx_row = idx_q[7:0];
        nib_row  = alo_q[15:0];
        aidx_row = alo_q[27:16];
      end
      2'd1: begin
        cidx_row = idx_q[15:8];
        nib_row  = alo_q[31:16];
        aidx_row = alo_q[39:28];
      end
      2'd2: begin
        cidx_row = idx_q[23:16];
        nib_row  = alo_q[47:32];
        aidx_row = alo_q[51:40];
      end
      default: begin
        cidx_row = idx_q[31:24];
        nib_row  = alo_q[63:48];
        aidx_row = alo_q[63:52];
      end
    endcase
  end

  logic [NumLanes-1:0][31:0] lane_texel;
  logic [NumLanes-1:0]       lane_ok;

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    lane_sel_t sel;
    assign sel.cidx = cidx_row[2*k +: 2];
    assign sel.nib  = nib_row[4*k +: 4];
    assign sel.aidx = aidx_row[3*k +: 3];

    bcdec_lane u_lane (
      .fmt_i       (fmt_q),
      .pal_i       (pal_q),
      .sel_i       (sel),
      .lane_idx_i  (2'(k)),
      .block_col_i (bcol_q),
      .width_i     (width_q),
      .texel_o     (lane_texel[k]),
      .col_ok_o    (lane_ok[k])
    );
  end

  // merge: vertical clip and output register
  logic [11:0] y;
  logic        row_ok;

  assign y      = {brow_q, row_cnt_q};
  assign row_ok = ({1'b0, y} < height_q);

  logic        out_valid_q;
  logic [1:0]  row_out_q;
  logic [NumLanes-1:0][31:0] texel_q;
  logic [3:0]  mask_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_out_q <= row_cnt_q;
      texel_q   <= lane_texel;
      mask_q    <= row_ok ? lane_ok : 4'd0;
      last_q    <= (row_cnt_q == 2'd3);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign row_in_block_o = row_out_q;
  assign texel_a_o      = texel_q[0];
  assign texel_b_o      = texel_q[1];
  assign texel_c_o      = texel_q[2];
  assign texel_d_o      = texel_q[3];
  assign texel_valid_o  = mask_q;
  assign last_row_o     = last_q;

  // a fresh block always starts at its top row
  a_start_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> blk_valid_q && row_cnt_q == 2'd0)
    else $error("block did not start at row zero");

  // an idle block register never holds off the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !blk_valid_q |-> !in_stall_o)
    else $error("input stalled with empty block register");

  // rows of one block follow one another with no gap once taken
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && row_in_block_o == $past(row_in_block_o) + 2'd1)
    else $error("row sequence broken");

endmodule

// ===== tb/bc1_bc2_bc3_block_decoder_tb.sv =====
// testbench for the bc1/bc2/bc3 block decoder: directed blocks, then random blocks per config
`timescale 1ns / 100ps

module bc1_bc2_bc3_block_decoder_tb;
  import bcdec_pkg::*;

  // index past the end of the register list, the block must ignore it
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int NUM_DIRECTED    = 22;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int DRAIN_CYCLES    = 4;

  typedef struct packed {
    logic [1:0]       row;
    logic [3:0][31:0] texel;
    logic [3:0]       valid;
    logic             last;
  } texel_row_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic [12:0] w;
    logic [12:0] h;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [9:0]  col;
    logic [9:0]  row;
    bit          known;
    logic [31:0] known_texel;
    logic [3:0]  known_valid;
  } block_case_t;

  // known rows carry one texel value for all 16 texels and one mask for all four rows
  localparam block_case_t BLOCK_CASES [NUM_DIRECTED] = '{
    '{FMT_BC1, 13'd4, 13'd4, 64'h0, 64'h0, 10'd0, 10'd0, 1'b1, 32'hFF00_0000, 4'hF},
    '{FMT_BC1, 13'd4, 13'd4, 64'h0000_0000_0000_FFFF, 64'h0, 10'd0, 10'd0,
      1'b1, 32'hFFFF_FFFF, 4'hF},
    '{FMT_BC1, 13'd4, 13'd4, 64'hFFFF_FFFF_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0, 10'd0,
      1'b1, 32'hFF55_5555, 4'hF},
    '{FMT_BC1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 10'd0, 10'd0,
      1'b1, 32'h0000_0000, 4'hF},
    '{FMT_BC1, 13'd4, 13'd4, 64'hAAAA_AAAA_FFFF_0000, 64'h0, 10'd0, 10'd0,
      1'b1, 32'hFF7F_7F7F, 4'hF},
    '{FMT_BC1, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1, 10'd0,
      1'b1, 32'h0000_0000, 4'h0},
    '{FMT_BC1, 13'd4, 13'd4, 64'h1B6C_E4D2_7C1F_83E0, 64'h0, 10'd0, 10'd1023,
      1'b0, 32'h0, 4'h0},
    '{FMT_BC1, 13'd4, 13'd4, 64'h5555_5555_F800_07E0, 64'h0, 10'd0, 10'd0,
      1'b1, 32'hFF00_00FF, 4'hF},
    '{FMT_BC2, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF, 10'd0, 10'd0,
      1'b1, 32'hFFFF_FFFF, 4'hF},
    '{FMT_BC2, 13'd4, 13'd4, 64'h0, 64'h0, 10'd0, 10'd0, 1'b1, 32'h0000_0000, 4'hF},
    '{FMT_BC2, 13'd4, 13'd4, 64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_001F_F800, 10'd0, 10'd0,
      1'b0, 32'h0, 4'h0},
    '{FMT_BC2, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_0000, 10'd0, 10'd0,
      1'b1, 32'hFFAA_AAAA, 4'hF},
    '{FMT_BC3, 13'd4, 13'd4, 64'h0000_0000_0000_00FF, 64'h0, 10'd0, 10'd0,
      1'b1, 32'hFF00_0000, 4'hF},
    '{FMT_BC3, 13'd4, 13'd4, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF, 10'd0, 10'd0,
      1'b1, 32'hFFFF_FFFF, 4'hF},
    '{FMT_BC3, 13'd4, 13'd4, 64'h0, 64'h0, 10'd0, 10'd0, 1'b1, 32'h0000_0000, 4'hF},
    '{FMT_BC3, 13'd4, 13'd4, 64'hFAC6_88FA_C688_10F0, 64'h1B6C_E4D2_7C1F_83E0, 10'd0, 10'd0,
      1'b0, 32'h0, 4'h0},
    '{FMT_RSVD, 13'd4, 13'd4, 64'hFAC6_88FA_C688_F010, 64'h1B6C_E4D2_7C1F_83E0, 10'd0, 10'd0,
      1'b0, 32'h0, 4'h0},
    '{FMT_BC1, 13'd0, 13'd4, 64'h0, 64'h0, 10'd0, 10'd0, 1'b1, 32'hFF00_0000, 4'h0},
    '{FMT_BC1, 13'd5, 13'd6, 64'h1B6C_E4D2_7C1F_83E0, 64'h0, 10'd1, 10'd1,
      1'b0, 32'h0, 4'h0},
    '{FMT_BC1, 13'd8191, 13'd8191, 64'h0, 64'h0, 10'd1023, 10'd1023,
      1'b1, 32'hFF00_0000, 4'hF},
    '{FMT_BC1, 13'd4097, 13'd4096, 64'h0, 64'h0, 10'd1023, 10'd1023,
      1'b1, 32'hFF00_0000, 4'hF},
    '{FMT_BC1, 13'd4096, 13'd1, 64'h39C6_0F0F_4208_C631, 64'h0, 10'd1023, 10'd0,
      1'b0, 32'h0, 4'h0}
  };

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_idx_i    = REG_FORMAT;
  logic [12:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [63:0] block_low_i  = '0;
  logic [63:0] block_high_i = '0;
  logic [9:0]  block_col_i  = '0;
  logic [9:0]  block_row_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [1:0]  row_in_block_o;
  logic [31:0] texel_a_o;
  logic [31:0] texel_b_o;
  logic [31:0] texel_c_o;
  logic [31:0] texel_d_o;
  logic [3:0]  texel_valid_o;
  logic        last_row_o;

  // register copy used for prediction, at reset values
  logic [1:0]  cur_format = FMT_BC1;
  logic [12:0] cur_width  = 13'd4;
  logic [12:0] cur_height = 13'd4;

  texel_row_t  rows_due [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;

  bc1_bc2_bc3_block_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .block_low_i   (block_low_i),
    .block_high_i  (block_high_i),
    .block_col_i   (block_col_i),
    .block_row_i   (block_row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .row_in_block_o(row_in_block_o),
    .texel_a_o     (texel_a_o),
    .texel_b_o     (texel_b_o),
    .texel_c_o     (texel_c_o),
    .texel_d_o     (texel_d_o),
    .texel_valid_o (texel_valid_o),
    .last_row_o    (last_row_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // expected rows are appended at the tail and taken from the head
  function automatic void queue_row(input texel_row_t entry);
    rows_due.insert(rows_due.size(), entry);
  endfunction

  // 565 channel widened to 8 bits by repeating its top bits; ch 0 red, 1 green, 2 blue
  function automatic int unsigned expand_channel(input logic [15:0] c, input int ch);
    int unsigned v;
    case (ch)
      0: begin
        v = c[15:11];
        return (v << 3) | (v >> 2);
      end
      1: begin
        v = c[10:5];
        return (v << 2) | (v >> 4);
      end
      default: begin
        v = c[4:0];
        return (v << 3) | (v >> 2);
      end
    endcase
  endfunction

  function automatic void predict_rows(input logic [63:0] lo, hi, input logic [9:0] col, row);
    logic [63:0] cblk;
    logic [15:0] c0, c1;
    int unsigned e0 [3];
    int unsigned e1 [3];
    int unsigned apal [8];
    int unsigned a0, a1, lim_w, lim_h, x, y, i;
    logic [31:0] pal [4];
    logic [31:0] texel;
    bit          punch;
    texel_row_t  res;
    cblk = (cur_format == FMT_BC1) ? lo : hi;
    c0 = cblk[15:0];
    c1 = cblk[31:16];
    punch = (cur_format == FMT_BC1) && (c0 <= c1);
    pal[0] = 32'hFF00_0000;
    pal[1] = 32'hFF00_0000;
    pal[2] = 32'hFF00_0000;
    pal[3] = punch ? 32'h0 : 32'hFF00_0000;
    for (int ch = 0; ch < 3; ch++) begin
      e0[ch] = expand_channel(c0, ch);
      e1[ch] = expand_channel(c1, ch);
      pal[0][8*ch +: 8] = 8'(e0[ch]);
      pal[1][8*ch +: 8] = 8'(e1[ch]);
      pal[2][8*ch +: 8] = punch ? 8'((e0[ch] + e1[ch]) / 2) : 8'((2 * e0[ch] + e1[ch]) / 3);
      pal[3][8*ch +: 8] = punch ? 8'd0 : 8'((e0[ch] + 2 * e1[ch]) / 3);
    end
    a0 = lo[7:0];
    a1 = lo[15:8];
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int s = 1; s < 7; s++) apal[s+1] = ((7 - s) * a0 + s * a1) / 7;
    end else begin
      for (int s = 1; s < 5; s++) apal[s+1] = ((5 - s) * a0 + s * a1) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    lim_w = (cur_width > MAX_DIM) ? MAX_DIM : cur_width;
    lim_h = (cur_height > MAX_DIM) ? MAX_DIM : cur_height;
    for (int r = 0; r < 4; r++) begin
      res = '0;
      res.row = 2'(r);
      res.last = (r == 3);
      y = row * 4 + r;
      for (int k = 0; k < 4; k++) begin
        i = r * 4 + k;
        texel = pal[cblk[32 + 2*i +: 2]];
        if (cur_format == FMT_BC2) begin
          texel[31:24] = 8'(lo[4*i +: 4] * 17);
        end else if (cur_format == FMT_BC3 || cur_format == FMT_RSVD) begin
          texel[31:24] = 8'(apal[lo[16 + 3*i +: 3]]);
        end
        res.texel[k] = texel;
        x = col * 4 + k;
        if (x < lim_w && y < lim_h) res.valid[k] = 1'b1;
      end
      queue_row(res);
    end
  endfunction

  function automatic logic [12:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4;
      3: return 13'd4096;
      4: return 13'd4097;
      5: return 13'd8191;
      6: return 13'($urandom_range(1, 64));
      default: return 13'($urandom_range(1, 8191));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_FORMAT: cur_format = data[1:0];
      REG_WIDTH:  cur_width  = data;
      REG_HEIGHT: cur_height = data;
      default: ;
    endcase
  endtask

  task automatic wait_rows_drained();
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_block(input logic [63:0] lo, hi, input logic [9:0] col, row,
                            input int gap, input bit known, input logic [31:0] known_texel,
                            input logic [3:0] known_valid);
    texel_row_t want;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    block_low_i  <= lo;
    block_high_i <= hi;
    block_col_i  <= col;
    block_row_i  <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (known) begin
      for (int r = 0; r < 4; r++) begin
        want.row   = 2'(r);
        want.texel = {4{known_texel}};
        want.valid = known_valid;
        want.last  = (r == 3);
        queue_row(want);
      end
    end else begin
      predict_rows(lo, hi, col, row);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("t=%0t %s: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    texel_row_t       want;
    logic [3:0][31:0] got;
    int               hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (rows_due.size() == 0) begin
        $display("t=%0t row transaction with nothing expected: row %0d", $time, row_in_block_o);
        mismatch_count++;
      end else begin
        want = rows_due.pop_front();
        got  = {texel_d_o, texel_c_o, texel_b_o, texel_a_o};
        compare_field("row_in_block", 32'(want.row), 32'(row_in_block_o));
        for (int k = 0; k < 4; k++) begin
          compare_field($sformatf("texel column %0d", k), want.texel[k], got[k]);
        end
        compare_field("texel_valid", 32'(want.valid), 32'(texel_valid_o));
        compare_field("last_row", 32'(want.last), 32'(last_row_o));
      end
    end
  end

  initial begin : stimulus
    block_case_t  bc;
    int           gap;
    int unsigned  span;
    logic [63:0]  lo, hi;
    logic [9:0]   blk_col, blk_row;
    logic [1:0]   fmt_pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first rows run on the reset register values
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      bc = BLOCK_CASES[n];
      if (bc.fmt != cur_format || bc.w != cur_width || bc.h != cur_height) begin
        in_valid_i <= 1'b0;
        wait_rows_drained();
        write_reg(REG_FORMAT, 13'(bc.fmt));
        write_reg(REG_WIDTH, bc.w);
        write_reg(REG_HEIGHT, bc.h);
        cfg_we_i <= 1'b0;
      end
      gap = $urandom_range(0, 10);
      send_block(bc.lo, bc.hi, bc.col, bc.row, gap, bc.known, bc.known_texel, bc.known_valid);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_rows_drained();
      fmt_pick = (p < 4) ? 2'(p) : 2'($urandom_range(0, 3));
      // junk above the format bits must be dropped
      write_reg(REG_FORMAT, {11'($urandom), fmt_pick});
      write_reg(REG_WIDTH, pick_dim());
      write_reg(REG_HEIGHT, pick_dim());
      if (p == 0 || $urandom_range(0, 2) == 0) write_reg(REG_SPARE, 13'($urandom));
      cfg_we_i <= 1'b0;
      no_idle = (p % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          wait_rows_drained();
        end
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        // equal endpoints hit the c0 == c1 and a0 == a1 boundaries
        if ($urandom_range(0, 5) == 0) begin
          lo[31:16] = lo[15:0];
          hi[31:16] = hi[15:0];
        end
        if ($urandom_range(0, 5) == 0) lo[15:8] = lo[7:0];
        if ($urandom_range(0, 1) == 0) begin
          blk_col = 10'($urandom_range(0, 1023));
          blk_row = 10'($urandom_range(0, 1023));
        end else begin
          // the other half stay inside the clamped image or just past its edge
          span = ((cur_width > MAX_DIM) ? MAX_DIM : cur_width) / 4 + 1;
          blk_col = 10'($urandom_range(0, (span > 1023) ? 1023 : span));
          span = ((cur_height > MAX_DIM) ? MAX_DIM : cur_height) / 4 + 1;
          blk_row = 10'($urandom_range(0, (span > 1023) ? 1023 : span));
        end
        gap = no_idle ? 0 : $urandom_range(0, 10);
        send_block(lo, hi, blk_col, blk_row, gap, 1'b0, 32'h0, 4'h0);
      end
    end

    in_valid_i <= 1'b0;
    wait_rows_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/bcdec_pkg.sv
src/bcdec_palette.sv
src/bcdec_lane.sv
src/bc1_bc2_bc3_block_decoder.sv
tb/bc1_bc2_bc3_block_decoder_tb.sv
